// ===== src/tti_pkg.sv =====
// Shared types, constants and arithmetic helpers of the trilinear table interpolator.
package tti_pkg;

  // Default grid limits
  localparam int MAX_THETA_POINTS_DEF = 32;
  localparam int MAX_DIH_POINTS_DEF   = 32;

  // Field widths
  localparam int INV_W    = 24;
  localparam int PTS_W    = 6;
  localparam int COS_W    = 16;
  localparam int DIH_W    = 15;
  localparam int VAL_W    = 32;
  localparam int LADDR_W  = 5;
  localparam int FRAC_W   = 17;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W   = VAL_W + 1 + FRAC_W + 1;
  localparam int NUM_BANKS = 8;

  // Register reset values
  localparam logic [INV_W-1:0] THETA_INV_STEP_RST = 24'd1015808;
  localparam logic [INV_W-1:0] DIH_INV_STEP_RST   = 24'd647168;
  localparam logic [PTS_W-1:0] THETA_POINTS_RST   = 6'd32;
  localparam logic [PTS_W-1:0] DIH_POINTS_RST     = 6'd32;

  // Fraction of exactly one
  localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THETA_INV_STEP = 2'd0,
    REG_DIH_INV_STEP   = 2'd1,
    REG_THETA_POINTS   = 2'd2,
    REG_DIH_POINTS     = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_QUERY = 1'b1
  } mode_t;

  // Fractions along the three axes plus the clamp flag
  typedef struct packed {
    logic [FRAC_W-1:0] fr;
    logic [FRAC_W-1:0] fc;
    logic [FRAC_W-1:0] fd;
    logic              oor;
  } frac_set_t;

  // (b - a) * f, full precision
  function automatic logic signed [PROD_W-1:0] lerp_mul(input logic signed [VAL_W-1:0] a,
                                                       input logic signed [VAL_W-1:0] b,
                                                       input logic [FRAC_W-1:0] f);
    logic signed [VAL_W:0] diff;
    diff = VAL_W'(0) + ({b[VAL_W-1], b} - {a[VAL_W-1], a});
    return PROD_W'(diff * $signed({1'b0, f}));
  endfunction

  // a + round_half_up(p / 65536); the result lies between the two end points
  function automatic logic signed [VAL_W-1:0] lerp_finish(input logic signed [VAL_W-1:0] a,
                                                          input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    s = p + PROD_W'(32768);
    return a + VAL_W'(s >>> 16);
  endfunction

endpackage

// ===== src/tti_ram.sv =====
// Generic simple dual-port RAM with registered read.
module tti_ram
  #(parameter int W = 32,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1)
  (input  logic          clk,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [W-1:0]  wdata,
   input  logic          re,
   input  logic [AW-1:0] raddr,
   output logic [W-1:0]  rdata);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/tti_locate.sv =====
// Grid location: scales the query coordinates and splits them into cell index and fraction.
module tti_locate
  import tti_pkg::*;
  #(parameter int MAX_THETA_POINTS = MAX_THETA_POINTS_DEF,
    parameter int MAX_DIH_POINTS = MAX_DIH_POINTS_DEF,
    localparam int IW_T = $clog2(MAX_THETA_POINTS),
    localparam int IW_D = $clog2(MAX_DIH_POINTS))
  (input  logic                clk,
   input  logic                rst_n,
   input  logic                adv,
   input  logic                take,
   input  logic                mode,
   input  logic [LADDR_W-1:0]  load_dih_bin,
   input  logic [LADDR_W-1:0]  load_row,
   input  logic [LADDR_W-1:0]  load_col,
   input  logic signed [VAL_W-1:0] load_value,
   input  logic signed [COS_W-1:0] cos_first,
   input  logic signed [COS_W-1:0] cos_second,
   input  logic [DIH_W-1:0]    dihedral,
   input  logic [INV_W-1:0]    theta_inv_step,
   input  logic [INV_W-1:0]    dih_inv_step,
   input  logic [PTS_W-1:0]    theta_points,
   input  logic [PTS_W-1:0]    dih_points,
   output logic                s3_valid,
   output logic                s3_mode,
   output logic [LADDR_W-1:0]  s3_load_dih,
   output logic [LADDR_W-1:0]  s3_load_row,
   output logic [LADDR_W-1:0]  s3_load_col,
   output logic [VAL_W-1:0]    s3_load_value,
   output logic [IW_T-1:0]     s3_idx_r,
   output logic [IW_T-1:0]     s3_idx_c,
   output logic [IW_D-1:0]     s3_idx_d,
   output frac_set_t           s3_fracs);

  localparam int PT_W = 9;
  localparam int IP_W = 10;

  // Pipeline valids
  logic v1_r, v2_r, v3_r;
  // Item fields along the stages
  logic mode1_r, mode2_r, mode3_r;
  logic [LADDR_W-1:0] ld1_r, lr1_r, lc1_r, ld2_r, lr2_r, lc2_r, ld3_r, lr3_r, lc3_r;
  logic [VAL_W-1:0] lv1_r, lv2_r, lv3_r;
  logic [COS_W-1:0] mag_r1_r, mag_c1_r;
  logic neg_r1_r, neg_c1_r, neg_r2_r, neg_c2_r;
  logic [DIH_W-1:0] dih1_r;
  logic [COS_W+INV_W-1:0] prod_r2_r, prod_c2_r;
  logic [DIH_W+INV_W-1:0] prod_d2_r;
  logic [IW_T-1:0] idx_r3_r, idx_c3_r;
  logic [IW_D-1:0] idx_d3_r;
  frac_set_t fracs3_r;

  logic signed [COS_W:0] off_r, off_c;
  logic [PT_W-1:0] t_eff, d_eff;
  logic [IP_W-1:0] t_last, d_last, ip_r, ip_c, ip_d;
  logic [IW_T-1:0] idx_r_nxt, idx_c_nxt;
  logic [IW_D-1:0] idx_d_nxt;
  frac_set_t fracs_nxt;

  // Offsets of the cosines from minus one
  assign off_r = {cos_first[COS_W-1], cos_first} + (COS_W+1)'(16384);
  assign off_c = {cos_second[COS_W-1], cos_second} + (COS_W+1)'(16384);

  // Point counts saturated to the usable range
  always_comb begin
    if (theta_points < PTS_W'(2)) begin
      t_eff = PT_W'(2);
    end else if (PT_W'(theta_points) > PT_W'(MAX_THETA_POINTS)) begin
      t_eff = PT_W'(MAX_THETA_POINTS);
    end else begin
      t_eff = PT_W'(theta_points);
    end
    if (dih_points < PTS_W'(2)) begin
      d_eff = PT_W'(2);
    end else if (PT_W'(dih_points) > PT_W'(MAX_DIH_POINTS)) begin
      d_eff = PT_W'(MAX_DIH_POINTS);
    end else begin
      d_eff = PT_W'(dih_points);
    end
  end

  assign t_last = IP_W'(t_eff - PT_W'(2));
  assign d_last = IP_W'(d_eff - PT_W'(2));
  assign ip_r = prod_r2_r[COS_W+INV_W-1:30];
  assign ip_c = prod_c2_r[COS_W+INV_W-1:30];
  assign ip_d = prod_d2_r[DIH_W+INV_W-1:29];

  // Split into index and fraction, clamping below the first cell and past the last cell
  always_comb begin
    fracs_nxt.oor = 1'b0;
    if (neg_r2_r) begin
      idx_r_nxt = '0;
      fracs_nxt.fr = '0;
      fracs_nxt.oor = 1'b1;
    end else if (ip_r > t_last) begin
      idx_r_nxt = t_last[IW_T-1:0];
      fracs_nxt.fr = FRAC_ONE;
      fracs_nxt.oor = 1'b1;
    end else begin
      idx_r_nxt = ip_r[IW_T-1:0];
      fracs_nxt.fr = {1'b0, prod_r2_r[29:14]};
    end
    if (neg_c2_r) begin
      idx_c_nxt = '0;
      fracs_nxt.fc = '0;
      fracs_nxt.oor = 1'b1;
    end else if (ip_c > t_last) begin
      idx_c_nxt = t_last[IW_T-1:0];
      fracs_nxt.fc = FRAC_ONE;
      fracs_nxt.oor = 1'b1;
    end else begin
      idx_c_nxt = ip_c[IW_T-1:0];
      fracs_nxt.fc = {1'b0, prod_c2_r[29:14]};
    end
    if (ip_d > d_last) begin
      idx_d_nxt = d_last[IW_D-1:0];
      fracs_nxt.fd = FRAC_ONE;
      fracs_nxt.oor = 1'b1;
    end else begin
      idx_d_nxt = ip_d[IW_D-1:0];
      fracs_nxt.fd = {1'b0, prod_d2_r[28:13]};
    end
  end

  // Valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= take;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Payload stages: capture, multiply, split
  always_ff @(posedge clk) begin
    if (adv) begin
      mode1_r  <= mode;
      ld1_r    <= load_dih_bin;
      lr1_r    <= load_row;
      lc1_r    <= load_col;
      lv1_r    <= load_value;
      mag_r1_r <= off_r[COS_W-1:0];
      mag_c1_r <= off_c[COS_W-1:0];
      neg_r1_r <= off_r[COS_W];
      neg_c1_r <= off_c[COS_W];
      dih1_r   <= dihedral;

      mode2_r   <= mode1_r;
      ld2_r     <= ld1_r;
      lr2_r     <= lr1_r;
      lc2_r     <= lc1_r;
      lv2_r     <= lv1_r;
      neg_r2_r  <= neg_r1_r;
      neg_c2_r  <= neg_c1_r;
      prod_r2_r <= (COS_W+INV_W)'(mag_r1_r) * (COS_W+INV_W)'(theta_inv_step);
      prod_c2_r <= (COS_W+INV_W)'(mag_c1_r) * (COS_W+INV_W)'(theta_inv_step);
      prod_d2_r <= (DIH_W+INV_W)'(dih1_r) * (DIH_W+INV_W)'(dih_inv_step);

      mode3_r  <= mode2_r;
      ld3_r    <= ld2_r;
      lr3_r    <= lr2_r;
      lc3_r    <= lc2_r;
      lv3_r    <= lv2_r;
      idx_r3_r <= idx_r_nxt;
      idx_c3_r <= idx_c_nxt;
      idx_d3_r <= idx_d_nxt;
      fracs3_r <= fracs_nxt;
    end
  end

  assign s3_valid      = v3_r;
  assign s3_mode       = mode3_r;
  assign s3_load_dih   = ld3_r;
  assign s3_load_row   = lr3_r;
  assign s3_load_col   = lc3_r;
  assign s3_load_value = lv3_r;
  assign s3_idx_r      = idx_r3_r;
  assign s3_idx_c      = idx_c3_r;
  assign s3_idx_d      = idx_d3_r;
  assign s3_fracs      = fracs3_r;

endmodule

// ===== src/tti_blend.sv =====
// Interpolation datapath: orders the eight corners and lerps along the three axes.
module tti_blend
  import tti_pkg::*;
  (input  logic             clk,
   input  logic             rst_n,
   input  logic             adv,
   input  logic             s3_query,
   input  logic [2:0]       s3_parity,
   input  frac_set_t        s3_fracs,
   input  logic [VAL_W-1:0] bank_rdata [NUM_BANKS],
   output logic             out_valid,
   output logic [VAL_W-1:0] interp_value,
   output logic             out_of_range);

  logic q4_r, q5_r, q6_r, q7_r, out_valid_r;
  logic [2:0] par4_r;
  frac_set_t fs4_r;
  logic [FRAC_W-1:0] fc5_r, fd5_r, fd6_r;
  logic oor5_r, oor6_r, oor7_r, oor_out_r;
  logic signed [VAL_W-1:0] a5_r [4];
  logic signed [PROD_W-1:0] p5_r [4];
  logic signed [VAL_W-1:0] a6_r [2];
  logic signed [PROD_W-1:0] p6_r [2];
  logic signed [VAL_W-1:0] a7_r;
  logic signed [PROD_W-1:0] p7_r;
  logic [VAL_W-1:0] value_out_r;

  logic signed [VAL_W-1:0] corner [NUM_BANKS];
  logic signed [VAL_W-1:0] a5_nxt [4];
  logic signed [PROD_W-1:0] p5_nxt [4];
  logic signed [VAL_W-1:0] lr [4];
  logic signed [VAL_W-1:0] lc [2];

  // Corner {dd,rr,cc} lives in the bank whose parity is its offset xor the base parity
  always_comb begin
    for (int k = 0; k < NUM_BANKS; k++) begin
      corner[k] = $signed(bank_rdata[3'(k) ^ par4_r]);
    end
  end

  // First axis: four lerps, pairs {dd,cc}
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      a5_nxt[k] = corner[{k[1], 1'b0, k[0]}];
      p5_nxt[k] = lerp_mul(corner[{k[1], 1'b0, k[0]}], corner[{k[1], 1'b1, k[0]}], fs4_r.fr);
    end
  end

  // Finish the first axis and the second axis
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      lr[k] = lerp_finish(a5_r[k], p5_r[k]);
    end
    for (int k = 0; k < 2; k++) begin
      lc[k] = lerp_finish(a6_r[k], p6_r[k]);
    end
  end

  // Valid chain and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q4_r        <= 1'b0;
      q5_r        <= 1'b0;
      q6_r        <= 1'b0;
      q7_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      q4_r        <= s3_query;
      q5_r        <= q4_r;
      q6_r        <= q5_r;
      q7_r        <= q6_r;
      out_valid_r <= q7_r;
    end
  end

  // Datapath stages
  always_ff @(posedge clk) begin
    if (adv) begin
      par4_r <= s3_parity;
      fs4_r  <= s3_fracs;

      for (int k = 0; k < 4; k++) begin
        a5_r[k] <= a5_nxt[k];
        p5_r[k] <= p5_nxt[k];
      end
      fc5_r  <= fs4_r.fc;
      fd5_r  <= fs4_r.fd;
      oor5_r <= fs4_r.oor;

      for (int k = 0; k < 2; k++) begin
        a6_r[k] <= lr[{k[0], 1'b0}];
        p6_r[k] <= lerp_mul(lr[{k[0], 1'b0}], lr[{k[0], 1'b1}], fc5_r);
      end
      fd6_r  <= fd5_r;
      oor6_r <= oor5_r;

      a7_r   <= lc[0];
      p7_r   <= lerp_mul(lc[0], lc[1], fd6_r);
      oor7_r <= oor6_r;

      value_out_r <= lerp_finish(a7_r, p7_r);
      oor_out_r   <= oor7_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign interp_value = value_out_r;
  assign out_of_range = oor_out_r;

endmodule

// ===== src/trilinear_table_interpolator.sv =====
// Top level of the trilinear table interpolator: registers, parity banks and pipeline control.
//
// Channel | Direction | Handshake              | Payload
// in_     | input     | in_valid / in_stall    | mode, load address and value, cosines, dihedral
// out_    | output    | out_valid / out_stall  | interp_value, out_of_range
// cfg_    | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One item per cycle unless the output stalls; a query is registered through locate, bank read and blend.
// The table is split into eight parity banks so all corners are read in the same cycle.
// Loads write at the stage where queries read, so later queries see earlier loads.
// Reset restores the registers; table contents are undefined until loaded.
// A stalled result freezes the whole pipeline, in_stall follows it.
module trilinear_table_interpolator
  import tti_pkg::*;
  #(parameter int MAX_THETA_POINTS = MAX_THETA_POINTS_DEF,
    parameter int MAX_DIH_POINTS = MAX_DIH_POINTS_DEF)
  (input  logic                    clk,
   input  logic                    rst_n,
   input  logic                    in_valid,
   output logic                    in_stall,
   input  logic                    in_mode,
   input  logic [LADDR_W-1:0]      in_load_dih_bin,
   input  logic [LADDR_W-1:0]      in_load_row,
   input  logic [LADDR_W-1:0]      in_load_col,
   input  logic signed [VAL_W-1:0] in_load_value,
   input  logic signed [COS_W-1:0] in_cos_first,
   input  logic signed [COS_W-1:0] in_cos_second,
   input  logic [DIH_W-1:0]        in_dihedral,
   output logic                    out_valid,
   input  logic                    out_stall,
   output logic signed [VAL_W-1:0] out_interp_value,
   output logic                    out_out_of_range,
   input  logic                    cfg_valid,
   output logic                    cfg_ready,
   input  logic [CFG_IDX_W-1:0]    cfg_index,
   input  logic [INV_W-1:0]        cfg_data);

  localparam int IW_T  = $clog2(MAX_THETA_POINTS);
  localparam int IW_D  = $clog2(MAX_DIH_POINTS);
  localparam int BT    = (MAX_THETA_POINTS + 1) / 2;
  localparam int BD    = (MAX_DIH_POINTS + 1) / 2;
  localparam int DEPTH = BD * BT * BT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [INV_W-1:0] theta_inv_step_r, dih_inv_step_r;
  logic [PTS_W-1:0] theta_points_r, dih_points_r;

  logic adv, take;
  logic s3_valid, s3_mode;
  logic [LADDR_W-1:0] s3_load_dih, s3_load_row, s3_load_col;
  logic [VAL_W-1:0] s3_load_value;
  logic [IW_T-1:0] s3_idx_r, s3_idx_c;
  logic [IW_D-1:0] s3_idx_d;
  frac_set_t s3_fracs;
  logic blend_valid;
  logic [VAL_W-1:0] blend_value;

  logic [AW-1:0] raddr [NUM_BANKS];
  logic [AW-1:0] waddr;
  logic [2:0] wbank;
  logic load_ok;
  logic [VAL_W-1:0] bank_rdata [NUM_BANKS];

  // Pipeline moves unless a result waits
  assign adv       = !(blend_valid && out_stall);
  assign in_stall  = !adv;
  assign take      = in_valid && adv;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      theta_inv_step_r <= THETA_INV_STEP_RST;
      dih_inv_step_r   <= DIH_INV_STEP_RST;
      theta_points_r   <= THETA_POINTS_RST;
      dih_points_r     <= DIH_POINTS_RST;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_THETA_INV_STEP: theta_inv_step_r <= cfg_data;
        REG_DIH_INV_STEP:   dih_inv_step_r   <= cfg_data;
        REG_THETA_POINTS:   theta_points_r   <= cfg_data[PTS_W-1:0];
        REG_DIH_POINTS:     dih_points_r     <= cfg_data[PTS_W-1:0];
        default: ;
      endcase
    end
  end

  tti_locate #(.MAX_THETA_POINTS(MAX_THETA_POINTS), .MAX_DIH_POINTS(MAX_DIH_POINTS)) u_locate (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .take           (take),
    .mode           (in_mode),
    .load_dih_bin   (in_load_dih_bin),
    .load_row       (in_load_row),
    .load_col       (in_load_col),
    .load_value     (in_load_value),
    .cos_first      (in_cos_first),
    .cos_second     (in_cos_second),
    .dihedral       (in_dihedral),
    .theta_inv_step (theta_inv_step_r),
    .dih_inv_step   (dih_inv_step_r),
    .theta_points   (theta_points_r),
    .dih_points     (dih_points_r),
    .s3_valid       (s3_valid),
    .s3_mode        (s3_mode),
    .s3_load_dih    (s3_load_dih),
    .s3_load_row    (s3_load_row),
    .s3_load_col    (s3_load_col),
    .s3_load_value  (s3_load_value),
    .s3_idx_r       (s3_idx_r),
    .s3_idx_c       (s3_idx_c),
    .s3_idx_d       (s3_idx_d),
    .s3_fracs       (s3_fracs)
  );

  // Bank read addresses: each axis takes the half index of whichever corner has that parity
  always_comb begin
    logic [IW_D:0] hd;
    logic [IW_T:0] hr, hc;
    for (int b = 0; b < NUM_BANKS; b++) begin
      hd = (IW_D+1)'(s3_idx_d) + (IW_D+1)'(s3_idx_d[0] ^ b[2]);
      hr = (IW_T+1)'(s3_idx_r) + (IW_T+1)'(s3_idx_r[0] ^ b[1]);
      hc = (IW_T+1)'(s3_idx_c) + (IW_T+1)'(s3_idx_c[0] ^ b[0]);
      raddr[b] = AW'((int'(hd >> 1) * BT + int'(hr >> 1)) * BT + int'(hc >> 1));
    end
  end

  // Load write address and bank
  assign load_ok = s3_valid && (s3_mode == MODE_LOAD) &&
                   (int'(s3_load_dih) < MAX_DIH_POINTS) &&
                   (int'(s3_load_row) < MAX_THETA_POINTS) &&
                   (int'(s3_load_col) < MAX_THETA_POINTS);
  assign wbank = {s3_load_dih[0], s3_load_row[0], s3_load_col[0]};
  assign waddr = AW'((int'(s3_load_dih >> 1) * BT + int'(s3_load_row >> 1)) * BT +
                     int'(s3_load_col >> 1));

  // Parity banks
  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    tti_ram #(.W(VAL_W), .DEPTH(DEPTH)) u_ram (
      .clk   (clk),
      .we    (adv && load_ok && (wbank == 3'(b))),
      .waddr (waddr),
      .wdata (s3_load_value),
      .re    (adv),
      .raddr (raddr[b]),
      .rdata (bank_rdata[b])
    );
  end

  tti_blend u_blend (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .s3_query     (s3_valid && (s3_mode == MODE_QUERY)),
    .s3_parity    ({s3_idx_d[0], s3_idx_r[0], s3_idx_c[0]}),
    .s3_fracs     (s3_fracs),
    .bank_rdata   (bank_rdata),
    .out_valid    (blend_valid),
    .interp_value (blend_value),
    .out_of_range (out_out_of_range)
  );

  assign out_valid        = blend_valid;
  assign out_interp_value = $signed(blend_value);

endmodule
